[rtl/tgarle_pkg.sv]
// Shared types and constants for the targa true-color RLE pixel decoder.
// No dependencies; compiled first.
package tgarle_pkg;

    localparam int DIM_BITS_DEF  = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int MIN_WIDTH     = 4;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] MAX_SEG_LEN  = 8'd128;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_RLE_ENABLE    = 3'd0,
        CFG_ALPHA_PRESENT = 3'd1,
        CFG_TOP_FIRST     = 3'd2,
        CFG_IMAGE_WIDTH   = 3'd3,
        CFG_IMAGE_HEIGHT  = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_ROW,
        ST_AVAIL,
        ST_LEN,
        ST_DEST,
        ST_EMIT
    } seq_state_t;

    typedef enum logic {
        ALU_SUB,
        ALU_ADD
    } alu_op_t;

    typedef struct packed {
        logic rle_enable;
        logic alpha_present;
        logic top_first;
    } cfg_flags_t;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [15:0] dest_row;
        logic [15:0] start_col;
        logic [7:0]  seg_length;
        logic        last_segment;
        logic        image_done;
    } seg_t;

endpackage

[rtl/tgarle_if.sv]
// Valid/ready channel interfaces: byte input and row-segment output.
// Depends on nothing; compiled after tgarle_pkg.
interface tgarle_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface tgarle_seg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] dest_row;
    logic [15:0] start_col;
    logic [7:0]  seg_length;
    logic        last_segment;
    logic        image_done;

    modport source (
        output valid, input ready,
        output red, output green, output blue, output alpha,
        output dest_row, output start_col, output seg_length,
        output last_segment, output image_done
    );
    modport sink (
        input valid, output ready,
        input red, input green, input blue, input alpha,
        input dest_row, input start_col, input seg_length,
        input last_segment, input image_done
    );
endinterface

[rtl/tgarle_alu.sv]
// Shared add/subtract unit with unsigned compare flag.
// Depends on tgarle_pkg.
module tgarle_alu #(
    parameter int DIM_BITS = tgarle_pkg::DIM_BITS_DEF
) (
    input  tgarle_pkg::alu_op_t  op,
    input  logic [DIM_BITS-1:0]  a,
    input  logic [DIM_BITS-1:0]  b,
    output logic [DIM_BITS-1:0]  result,
    output logic                 ge
);
    import tgarle_pkg::*;

    logic [DIM_BITS:0] sum;

    always_comb
    begin
        if (op == ALU_SUB)
        begin
            sum = {1'b0, a} + {1'b0, ~b} + {{DIM_BITS{1'b0}}, 1'b1};
        end
        else
        begin
            sum = {1'b0, a} + {1'b0, b};
        end
        result = sum[DIM_BITS-1:0];
        // carry out of a - b means no borrow: a >= b
        ge = (op == ALU_SUB) ? sum[DIM_BITS] : 1'b0;
    end

endmodule

[rtl/tgarle_seq.sv]
// Byte parser and segment sequencer; drives one shared tgarle_alu.
// Depends on tgarle_pkg and tgarle_alu.
module tgarle_seq #(
    parameter int DIM_BITS = tgarle_pkg::DIM_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tgarle_pkg::cfg_flags_t  flags,
    input  logic [DIM_BITS-1:0]     img_w,
    input  logic [DIM_BITS-1:0]     img_h,
    input  logic                    in_valid,
    input  logic [7:0]              in_data,
    output logic                    in_ready,
    output logic                    seg_valid,
    output tgarle_pkg::seg_t        seg,
    input  logic                    seg_ready
);
    import tgarle_pkg::*;

    seq_state_t state_reg, state_next;

    logic [1:0]          phase_reg, phase_next;
    logic [23:0]         gather_reg, gather_next;
    logic                await_hdr_reg, await_hdr_next;
    logic                repeat_reg, repeat_next;
    logic [6:0]          left_reg, left_next;
    logic [DIM_BITS-1:0] row_reg, row_next;
    logic [DIM_BITS-1:0] col_reg, col_next;
    logic                finished_reg, finished_next;
    logic [7:0]          red_reg, red_next;
    logic [7:0]          green_reg, green_next;
    logic [7:0]          blue_reg, blue_next;
    logic [7:0]          alpha_reg, alpha_next;
    logic [7:0]          count_reg, count_next;
    logic [7:0]          len_reg, len_next;
    logic                cnt_ge_reg, cnt_ge_next;
    logic [DIM_BITS-1:0] avail_reg, avail_next;
    logic [DIM_BITS-1:0] dest_reg, dest_next;

    alu_op_t             alu_op;
    logic [DIM_BITS-1:0] alu_a, alu_b, alu_res;
    logic                alu_ge;

    logic                accept;
    logic                complete;
    logic [DIM_BITS-1:0] row_inc;
    logic [7:0]          remain;
    logic                seg_done;
    logic                seg_last;
    logic                push;

    tgarle_alu #(.DIM_BITS(DIM_BITS)) u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_res),
        .ge     (alu_ge)
    );

    assign accept   = in_valid && in_ready;
    assign complete = (phase_reg == 2'd3) || (phase_reg == 2'd2 && !flags.alpha_present);
    assign row_inc  = row_reg + DIM_BITS'(1);
    assign remain   = count_reg - len_reg;
    // full row reached on the last row of the image
    assign seg_done = cnt_ge_reg && (dest_reg == '0);
    assign seg_last = seg_done || (remain == 8'd0);
    assign push     = seg_valid && seg_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !finished_reg && !(flags.rle_enable && await_hdr_reg)
                    && complete)
                begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:  state_next = ST_ROW;
            ST_ROW:   state_next = alu_ge ? ST_IDLE : ST_AVAIL;
            ST_AVAIL: state_next = ST_LEN;
            ST_LEN:   state_next = ST_DEST;
            ST_DEST:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (push)
                begin
                    state_next = seg_last ? ST_IDLE : ST_WRAP;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs and shared-unit operand select
    always_comb
    begin
        in_ready  = 1'b0;
        seg_valid = 1'b0;
        alu_op    = ALU_SUB;
        alu_a     = '0;
        alu_b     = '0;
        case (state_reg)
            ST_IDLE:  in_ready = 1'b1;
            ST_WRAP:
            begin
                alu_a = col_reg;
                alu_b = img_w;
            end
            ST_ROW:
            begin
                alu_a = row_reg;
                alu_b = img_h;
            end
            ST_AVAIL:
            begin
                alu_a = img_w;
                alu_b = col_reg;
            end
            ST_LEN:
            begin
                alu_a = DIM_BITS'(count_reg);
                alu_b = avail_reg;
            end
            ST_DEST:
            begin
                alu_a = img_h;
                alu_b = row_inc;
            end
            ST_EMIT:
            begin
                seg_valid = 1'b1;
                alu_op    = ALU_ADD;
                alu_a     = col_reg;
                alu_b     = DIM_BITS'(len_reg);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        seg.red          = red_reg;
        seg.green        = green_reg;
        seg.blue         = blue_reg;
        seg.alpha        = alpha_reg;
        seg.dest_row     = 16'(flags.top_first ? row_reg : dest_reg);
        seg.start_col    = 16'(col_reg);
        seg.seg_length   = len_reg;
        seg.last_segment = seg_last;
        seg.image_done   = seg_done;
    end

    // datapath next values
    always_comb
    begin
        phase_next     = phase_reg;
        gather_next    = gather_reg;
        await_hdr_next = await_hdr_reg;
        repeat_next    = repeat_reg;
        left_next      = left_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        finished_next  = finished_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        alpha_next     = alpha_reg;
        count_next     = count_reg;
        len_next       = len_reg;
        cnt_ge_next    = cnt_ge_reg;
        avail_next     = avail_reg;
        dest_next      = dest_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !finished_reg)
                begin
                    if (flags.rle_enable && await_hdr_reg)
                    begin
                        repeat_next    = in_data[7];
                        left_next      = in_data[6:0];
                        await_hdr_next = 1'b0;
                        phase_next     = 2'd0;
                    end
                    else if (!complete)
                    begin
                        case (phase_reg)
                            2'd0:    gather_next[7:0]   = gather_reg[7:0] | in_data;
                            2'd1:    gather_next[15:8]  = gather_reg[15:8] | in_data;
                            default: gather_next[23:16] = gather_reg[23:16] | in_data;
                        endcase
                        phase_next = phase_reg + 2'd1;
                    end
                    else
                    begin
                        if (phase_reg == 2'd2)
                        begin
                            red_next   = in_data;
                            alpha_next = ALPHA_OPAQUE;
                        end
                        else
                        begin
                            red_next   = gather_reg[23:16];
                            alpha_next = in_data;
                        end
                        green_next  = gather_reg[15:8];
                        blue_next   = gather_reg[7:0];
                        phase_next  = 2'd0;
                        gather_next = '0;
                        count_next  = 8'd1;
                        if (flags.rle_enable)
                        begin
                            if (repeat_reg)
                            begin
                                count_next     = {1'b0, left_reg} + 8'd1;
                                left_next      = '0;
                                await_hdr_next = 1'b1;
                            end
                            else if (left_reg == '0)
                            begin
                                await_hdr_next = 1'b1;
                            end
                            else
                            begin
                                left_next = left_reg - 7'd1;
                            end
                        end
                    end
                end
            end
            ST_WRAP:
            begin
                if (alu_ge)
                begin
                    col_next = '0;
                    row_next = row_inc;
                end
            end
            ST_ROW:
            begin
                if (alu_ge)
                begin
                    finished_next = 1'b1;
                end
            end
            ST_AVAIL: avail_next = alu_res;
            ST_LEN:
            begin
                cnt_ge_next = alu_ge;
                len_next    = alu_ge ? avail_reg[7:0] : count_reg;
            end
            ST_DEST:  dest_next = alu_res;
            ST_EMIT:
            begin
                if (push)
                begin
                    col_next   = alu_res;
                    count_next = remain;
                    if (seg_done)
                    begin
                        finished_next = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            gather_reg    <= '0;
            await_hdr_reg <= 1'b1;
            repeat_reg    <= 1'b0;
            left_reg      <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            finished_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            gather_reg    <= gather_next;
            await_hdr_reg <= await_hdr_next;
            repeat_reg    <= repeat_next;
            left_reg      <= left_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            finished_reg  <= finished_next;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg    <= red_next;
        green_reg  <= green_next;
        blue_reg   <= blue_next;
        alpha_reg  <= alpha_next;
        count_reg  <= count_next;
        len_reg    <= len_next;
        cnt_ge_reg <= cnt_ge_next;
        avail_reg  <= avail_next;
        dest_reg   <= dest_next;
    end

endmodule

[rtl/tga_truecolor_rle_pixel_decoder_unit.sv]
// Targa true-color RLE pixel decoder, top level.
// Header and partial-pixel bytes are taken in the idle state; a pixel byte then drives,
// per row segment it yields, one shared add/sub unit through wrap, row check, room,
// length, flipped row and column update. Once the rows are used up, bytes are taken and dropped.
// The first word passes those sequencer steps and then the one-word output register;
// a stalled sink holds the sequencer. Reset: async active low; counters cleared,
// awaiting a packet header, config to defaults.
module tga_truecolor_rle_pixel_decoder_unit #(
    parameter int DIM_BITS = tgarle_pkg::DIM_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tgarle_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [tgarle_pkg::CFG_DATA_BITS-1:0] cfg_data,
    tgarle_byte_if.sink                          in_ch,
    tgarle_seg_if.source                         out_ch
);
    import tgarle_pkg::*;

    // configuration registers
    cfg_flags_t                flags_reg;
    logic [CFG_DATA_BITS-1:0]  width_reg;
    logic [CFG_DATA_BITS-1:0]  height_reg;

    // effective image size: masked to DIM_BITS, width at least 4, height at least 1
    logic [DIM_BITS-1:0] w_raw, h_raw, img_w, img_h;

    // sequencer to output register
    logic  seg_valid;
    logic  seg_ready;
    seg_t  seg;

    // output register
    logic  out_valid_reg;
    seg_t  out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg  <= '0;
            width_reg  <= CFG_DATA_BITS'(MIN_WIDTH);
            height_reg <= CFG_DATA_BITS'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RLE_ENABLE:    flags_reg.rle_enable    <= cfg_data[0];
                CFG_ALPHA_PRESENT: flags_reg.alpha_present <= cfg_data[0];
                CFG_TOP_FIRST:     flags_reg.top_first     <= cfg_data[0];
                CFG_IMAGE_WIDTH:   width_reg               <= cfg_data;
                CFG_IMAGE_HEIGHT:  height_reg              <= cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    assign w_raw = width_reg[DIM_BITS-1:0];
    assign h_raw = height_reg[DIM_BITS-1:0];
    assign img_w = (w_raw < DIM_BITS'(MIN_WIDTH)) ? DIM_BITS'(MIN_WIDTH) : w_raw;
    assign img_h = (h_raw == '0) ? DIM_BITS'(1) : h_raw;

    tgarle_seq #(.DIM_BITS(DIM_BITS)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .flags     (flags_reg),
        .img_w     (img_w),
        .img_h     (img_h),
        .in_valid  (in_ch.valid),
        .in_data   (in_ch.data_byte),
        .in_ready  (in_ch.ready),
        .seg_valid (seg_valid),
        .seg       (seg),
        .seg_ready (seg_ready)
    );

    // output register: takes a new word when empty or draining this cycle
    assign seg_ready = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (seg_valid && seg_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seg_valid && seg_ready)
        begin
            out_reg <= seg;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.red          = out_reg.red;
    assign out_ch.green        = out_reg.green;
    assign out_ch.blue         = out_reg.blue;
    assign out_ch.alpha        = out_reg.alpha;
    assign out_ch.dest_row     = out_reg.dest_row;
    assign out_ch.start_col    = out_reg.start_col;
    assign out_ch.seg_length   = out_reg.seg_length;
    assign out_ch.last_segment = out_reg.last_segment;
    assign out_ch.image_done   = out_reg.image_done;

    // the sequencer never takes a byte while it is offering a segment
    a_no_accept_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && seg_valid))
        else $error("byte accepted while a segment is pending");

    // segment lengths stay within one RLE packet
    a_seg_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid |-> (seg.seg_length != 8'd0) && (seg.seg_length <= MAX_SEG_LEN))
        else $error("segment length out of range");

    // the segment that completes the image always closes its byte
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.image_done |-> out_ch.last_segment)
        else $error("image_done without last_segment");

    // a held output word stays put until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_reg))
        else $error("output word changed while stalled");

endmodule
